>>> src/cddd_pkg.sv
package cddd_pkg;

    localparam int DAY_W   = 5;
    localparam int MONTH_W = 4;
    localparam int YEAR_W  = 14;
    localparam int COUNT_W = 22;

    // Shifted year (year + 400) and the day number both need one bit more.
    localparam int YY_W    = YEAR_W + 1;
    localparam int DNUM_W  = 23;
    localparam int DOY_W   = 9;

    localparam int YEAR_OFFSET = 400;
    localparam int DAYS_PER_YEAR = 365;

    // x / 25 is taken as (x * 5243) >> 17, exact for every x below 43690.
    localparam int RECIP25     = 5243;
    localparam int RECIP_SHIFT = 17;
    localparam int PROD_W      = 26;
    localparam int QUOT_W      = 8;
    localparam int CHK_W       = 13;

    localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

    typedef struct packed {
        logic [DAY_W-1:0]   day;
        logic [MONTH_W-1:0] month;
        logic [YEAR_W-1:0]  year;
    } date_t;

    typedef struct packed {
        logic              ok;
        logic [DNUM_W-1:0] num;
    } date_num_t;

    // Days in a month; zero for a month code outside one to twelve.
    function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                    input logic leap);
        logic [DAY_W-1:0] len;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = leap ? 5'd29 : 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    // Days before a month in a year that starts in March, (153 * mm + 2) / 5.
    function automatic logic [DOY_W-1:0] march_offset(input logic [MONTH_W-1:0] mm);
        logic [DOY_W-1:0] off;
        case (mm)
            4'd0:    off = 9'd0;
            4'd1:    off = 9'd31;
            4'd2:    off = 9'd61;
            4'd3:    off = 9'd92;
            4'd4:    off = 9'd122;
            4'd5:    off = 9'd153;
            4'd6:    off = 9'd184;
            4'd7:    off = 9'd214;
            4'd8:    off = 9'd245;
            4'd9:    off = 9'd275;
            4'd10:   off = 9'd306;
            4'd11:   off = 9'd337;
            default: off = 9'd0;
        endcase
        return off;
    endfunction

endpackage

>>> src/cddd_ifs.sv
interface cddd_in_if
    import cddd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [DAY_W-1:0]   start_day;
    logic [MONTH_W-1:0] start_month;
    logic [YEAR_W-1:0]  start_year;
    logic [DAY_W-1:0]   end_day;
    logic [MONTH_W-1:0] end_month;
    logic [YEAR_W-1:0]  end_year;
    logic               include_end;

    modport source (
        output valid, start_day, start_month, start_year,
               end_day, end_month, end_year, include_end,
        input  ready
    );

    modport sink (
        input  valid, start_day, start_month, start_year,
               end_day, end_month, end_year, include_end,
        output ready
    );
endinterface

interface cddd_out_if
    import cddd_pkg::*;
();
    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] day_count;
    logic               invalid_date;

    modport source (
        output valid, day_count, invalid_date,
        input  ready
    );

    modport sink (
        input  valid, day_count, invalid_date,
        output ready
    );
endinterface

>>> src/cddd_date_pipe.sv
module cddd_date_pipe
    import cddd_pkg::*;
(
    input  logic      clk,
    input  logic      en,
    input  date_t     date,
    output date_num_t result
);

    // Stage one: shifted year, March-based month and the reciprocal products.
    logic               early;
    logic [YY_W-1:0]    yy_next;
    logic [4:0]         mm_wide;
    logic [MONTH_W-1:0] mm_next;
    logic [PROD_W-1:0]  p100_next;
    logic [PROD_W-1:0]  p400_next;
    logic [PROD_W-1:0]  l100_next;
    logic [PROD_W-1:0]  l400_next;

    date_t              s1_date_reg;
    logic [YY_W-1:0]    s1_yy_reg;
    logic [MONTH_W-1:0] s1_mm_reg;
    logic [PROD_W-1:0]  s1_p100_reg;
    logic [PROD_W-1:0]  s1_p400_reg;
    logic [PROD_W-1:0]  s1_l100_reg;
    logic [PROD_W-1:0]  s1_l400_reg;

    always_comb
    begin
        early     = (date.month <= MONTH_W'(2));
        yy_next   = YY_W'(date.year) + YY_W'(YEAR_OFFSET) - YY_W'(early);
        mm_wide   = 5'(date.month) + (early ? 5'd12 : 5'd0) - 5'd3;
        mm_next   = mm_wide[MONTH_W-1:0];
        p100_next = PROD_W'(yy_next[YY_W-1:2]) * PROD_W'(RECIP25);
        p400_next = PROD_W'(yy_next[YY_W-1:4]) * PROD_W'(RECIP25);
        l100_next = PROD_W'(date.year[YEAR_W-1:2]) * PROD_W'(RECIP25);
        l400_next = PROD_W'(date.year[YEAR_W-1:4]) * PROD_W'(RECIP25);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s1_date_reg <= date;
            s1_yy_reg   <= yy_next;
            s1_mm_reg   <= mm_next;
            s1_p100_reg <= p100_next;
            s1_p400_reg <= p400_next;
            s1_l100_reg <= l100_next;
            s1_l400_reg <= l400_next;
        end
    end

    // Stage two: leap year, date check and day of the March-based year.
    logic [QUOT_W-1:0] q100_next;
    logic [QUOT_W-1:0] q400_next;
    logic [QUOT_W-1:0] lq100;
    logic [QUOT_W-1:0] lq400;
    logic              div4;
    logic              div100;
    logic              div400;
    logic              leap;
    logic [DAY_W-1:0]  mlen;
    logic              ok_next;
    logic [DOY_W-1:0]  doy_next;

    logic              s2_ok_reg;
    logic [DOY_W-1:0]  s2_doy_reg;
    logic [YY_W-1:0]   s2_yy_reg;
    logic [QUOT_W-1:0] s2_q100_reg;
    logic [QUOT_W-1:0] s2_q400_reg;

    always_comb
    begin
        q100_next = s1_p100_reg[RECIP_SHIFT +: QUOT_W];
        q400_next = s1_p400_reg[RECIP_SHIFT +: QUOT_W];
        lq100     = s1_l100_reg[RECIP_SHIFT +: QUOT_W];
        lq400     = s1_l400_reg[RECIP_SHIFT +: QUOT_W];
        div4      = (s1_date_reg.year[1:0] == 2'd0);
        div100    = div4 && (CHK_W'(s1_date_reg.year[YEAR_W-1:2])
                             == CHK_W'(lq100) * CHK_W'(25));
        div400    = (s1_date_reg.year[3:0] == 4'd0)
                    && (CHK_W'(s1_date_reg.year[YEAR_W-1:4]) == CHK_W'(lq400) * CHK_W'(25));
        leap      = (div4 && !div100) || div400;
        mlen      = month_days(s1_date_reg.month, leap);
        ok_next   = (s1_date_reg.day != DAY_W'(0)) && (s1_date_reg.day <= mlen);
        doy_next  = march_offset(s1_mm_reg) + DOY_W'(s1_date_reg.day) - DOY_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s2_ok_reg   <= ok_next;
            s2_doy_reg  <= doy_next;
            s2_yy_reg   <= s1_yy_reg;
            s2_q100_reg <= q100_next;
            s2_q400_reg <= q400_next;
        end
    end

    // Stage three: closed-form day number.
    logic [DNUM_W:0] num_wide;
    date_num_t       s3_reg;

    always_comb
    begin
        num_wide = (DNUM_W+1)'(s2_yy_reg) * (DNUM_W+1)'(DAYS_PER_YEAR)
                   + (DNUM_W+1)'(s2_yy_reg[YY_W-1:2])
                   + (DNUM_W+1)'(s2_q400_reg)
                   - (DNUM_W+1)'(s2_q100_reg)
                   + (DNUM_W+1)'(s2_doy_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s3_reg.ok  <= s2_ok_reg;
            s3_reg.num <= num_wide[DNUM_W-1:0];
        end
    end

    assign result = s3_reg;

endmodule

>>> src/calendar_date_difference_days_unit.sv
// Days between two Gregorian dates.
//
// The req channel carries one word per date pair: start and end day, month
// and year, and the include_end flag. The rsp channel returns one word for
// each: day_count and invalid_date. A bad month or day in either date gives
// invalid_date set and a count of zero; an end not after the start gives a
// count of include_end alone, and counts beyond 22 bits saturate.
//
// The unit is a four-stage pipeline: reciprocal products, leap year and date
// check, day number, then subtraction into the output register. While rsp
// is not stalled a new word can be taken in every cycle, so throughput is
// one word per cycle.
//
// When the output register is full and not being taken, the whole
// pipeline holds and req.ready drops at once; nothing is lost or
// repeated. Reset clears all valid bits, so rsp.valid is low after reset.
module calendar_date_difference_days_unit
    import cddd_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cddd_in_if.sink        req,
    cddd_out_if.source     rsp
);

    logic advance;
    logic v1_reg, v2_reg, v3_reg;
    logic inc1_reg, inc2_reg, inc3_reg;
    logic out_valid_reg;
    logic [COUNT_W-1:0] count_reg;
    logic invalid_reg;

    date_t     start_date;
    date_t     end_date;
    date_num_t start_num;
    date_num_t end_num;

    assign advance   = !out_valid_reg || rsp.ready;
    assign req.ready = advance;

    assign start_date = '{day: req.start_day, month: req.start_month, year: req.start_year};
    assign end_date   = '{day: req.end_day, month: req.end_month, year: req.end_year};

    cddd_date_pipe u_start
    (
        .clk    (clk),
        .en     (advance),
        .date   (start_date),
        .result (start_num)
    );

    cddd_date_pipe u_end
    (
        .clk    (clk),
        .en     (advance),
        .date   (end_date),
        .result (end_num)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= req.valid;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            out_valid_reg <= v3_reg;
        end
    end

    // Final stage: difference, include flag and saturation.
    logic               both_ok;
    logic [DNUM_W-1:0]  diff;
    logic [DNUM_W:0]    sum;
    logic [COUNT_W-1:0] count_next;

    always_comb
    begin
        both_ok = start_num.ok && end_num.ok;
        diff    = (start_num.num < end_num.num) ? (end_num.num - start_num.num)
                                                : DNUM_W'(0);
        sum     = (DNUM_W+1)'(diff) + (DNUM_W+1)'(inc3_reg);
        if (!both_ok)
            count_next = COUNT_W'(0);
        else if (sum > (DNUM_W+1)'(COUNT_MAX))
            count_next = COUNT_MAX;
        else
            count_next = sum[COUNT_W-1:0];
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            inc1_reg    <= req.include_end;
            inc2_reg    <= inc1_reg;
            inc3_reg    <= inc2_reg;
            count_reg   <= count_next;
            invalid_reg <= !both_ok;
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.day_count    = count_reg;
    assign rsp.invalid_date = invalid_reg;

    a_invalid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && invalid_reg |-> count_reg == COUNT_W'(0))
        else $error("invalid date word carries a nonzero count");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable({v1_reg, v2_reg, v3_reg, out_valid_reg}))
        else $error("pipeline moved while the output was stalled");

    a_word_arrives: assert property (@(posedge clk) disable iff (!rst_n)
        advance && v3_reg |=> out_valid_reg)
        else $error("word lost between the last stage and the output");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
    import cddd_pkg::*;

    typedef struct packed {
        date_t from_date;
        date_t to_date;
        logic  inc;
    } date_pair_t;

    // Holds the day counts still owed by the block, oldest first, and checks each
    // returned word against them.
    class day_count_scoreboard;
        typedef struct packed {
            logic [COUNT_W-1:0] count;
            logic               bad;
        } outcome_t;

        outcome_t    owed_q[$];
        int unsigned errors;
        int unsigned checked;
        int unsigned invalid_seen;
        int unsigned saturated_seen;

        function new();
            errors = 0;
            checked = 0;
            invalid_seen = 0;
            saturated_seen = 0;
        endfunction

        static function bit is_leap(int unsigned y);
            return (y % 400 == 0) || ((y % 4 == 0) && (y % 100 != 0));
        endfunction

        static function int unsigned month_length(int unsigned y, int unsigned m);
            int unsigned len;
            case (m)
                1, 3, 5, 7, 8, 10, 12: len = 31;
                4, 6, 9, 11:           len = 30;
                2:                     len = is_leap(y) ? 29 : 28;
                default:               len = 0;
            endcase
            return len;
        endfunction

        static function bit date_valid(date_t dt);
            return (dt.day >= 1) && (dt.day <= month_length(dt.year, dt.month));
        endfunction

        // Days since a point 400 years before year zero, with the year taken
        // to start in March so that the leap day falls at its end.
        static function int unsigned serial_day(date_t dt);
            int unsigned jan_feb;
            int unsigned yy;
            int unsigned mm;
            int unsigned into_year;
            jan_feb   = (dt.month <= 2) ? 1 : 0;
            yy        = dt.year + 400 - jan_feb;
            mm        = dt.month + 12 * jan_feb - 3;
            into_year = (153 * mm + 2) / 5 + dt.day - 1;
            return 365 * yy + yy / 4 - yy / 100 + yy / 400 + into_year;
        endfunction

        function void note_request(date_pair_t p);
            outcome_t    want;
            int unsigned a;
            int unsigned b;
            int unsigned span;
            want.count = '0;
            want.bad   = 1'b0;
            if (!date_valid(p.from_date) || !date_valid(p.to_date))
            begin
                want.bad = 1'b1;
                invalid_seen++;
            end
            else
            begin
                a    = serial_day(p.from_date);
                b    = serial_day(p.to_date);
                span = ((a < b) ? (b - a) : 0) + p.inc;
                if (span > COUNT_MAX)
                begin
                    span = COUNT_MAX;
                    saturated_seen++;
                end
                want.count = span[COUNT_W-1:0];
            end
            owed_q.push_back(want);
        endfunction

        function void check_result(logic [COUNT_W-1:0] count, logic bad);
            outcome_t want;
            checked++;
            if (owed_q.size() == 0)
            begin
                $error("unexpected result word: day_count %0d, invalid_date %0b",
                       count, bad);
                errors++;
                return;
            end
            want = owed_q.pop_front();
            if (count !== want.count)
            begin
                $error("day_count: expected %0d, actual %0d", want.count, count);
                errors++;
            end
            if (bad !== want.bad)
            begin
                $error("invalid_date: expected %0b, actual %0b", want.bad, bad);
                errors++;
            end
        endfunction

        function int unsigned pending();
            return owed_q.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;

    cddd_in_if  req_if ();
    cddd_out_if rsp_if ();

    calendar_date_difference_days_unit DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    day_count_scoreboard sb;

    bit          idle_on;
    int unsigned burst_left;
    int unsigned stall_style;
    int unsigned hold_request;
    int unsigned holds_done;
    int unsigned pairs_sent;

    initial
    begin
        clk = 1'b0;
        forever
        begin
            #5 clk = 1'b1;
            #5 clk = 1'b0;
        end
    end

    initial
    begin
        #3000000;
        $display("CHECKS FAILED");
        $finish;
    end

    // Receiver: a stall pattern chosen per phase, and a long hold-off whenever
    // one is asked for, counted here in cycles.
    initial
    begin
        int unsigned hold_len;
        int unsigned cyc;
        cyc = 0;
        rsp_if.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            cyc++;
            if (hold_request > 0)
            begin
                hold_len = hold_request;
                hold_request = 0;
                rsp_if.ready <= 1'b0;
                repeat (hold_len) @(posedge clk);
            end
            else
            begin
                case (stall_style)
                    0:       rsp_if.ready <= 1'b1;
                    1:       rsp_if.ready <= ($urandom_range(0, 3) != 0);
                    2:       rsp_if.ready <= ((cyc % 7) < 4);
                    default: rsp_if.ready <= ($urandom_range(0, 9) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp_if.valid && rsp_if.ready)
            sb.check_result(rsp_if.day_count, rsp_if.invalid_date);
    end

    function automatic date_t make_date(int unsigned d, int unsigned m, int unsigned y);
        date_t dt;
        dt.day   = d[DAY_W-1:0];
        dt.month = m[MONTH_W-1:0];
        dt.year  = y[YEAR_W-1:0];
        return dt;
    endfunction

    function automatic date_pair_t make_pair(int unsigned sd, int unsigned sm, int unsigned sy,
                                             int unsigned ed, int unsigned em, int unsigned ey,
                                             bit inc);
        date_pair_t p;
        p.from_date = make_date(sd, sm, sy);
        p.to_date   = make_date(ed, em, ey);
        p.inc       = inc;
        return p;
    endfunction

    function automatic date_t random_valid_date(int unsigned y_lo, int unsigned y_hi);
        int unsigned y;
        int unsigned m;
        y = $urandom_range(y_hi, y_lo);
        m = $urandom_range(12, 1);
        return make_date($urandom_range(day_count_scoreboard::month_length(y, m), 1), m, y);
    endfunction

    // Spoils a good date: a month outside the year, a day of zero, or a day past
    // the end of its month.
    function automatic date_t spoil_date(date_t dt);
        date_t       bad;
        int unsigned len;
        bad = dt;
        len = day_count_scoreboard::month_length(dt.year, dt.month);
        case ($urandom_range(2, 0))
            0:       bad.month = ($urandom_range(1, 0) == 0) ? 4'd0
                                                             : 4'($urandom_range(15, 13));
            1:       bad.day = '0;
            default: bad.day = (len < 31) ? 5'($urandom_range(31, len + 1)) : 5'd0;
        endcase
        return bad;
    endfunction

    function automatic date_pair_t random_pair();
        date_pair_t  p;
        int unsigned pick;
        pick  = $urandom_range(99, 0);
        p.inc = 1'($urandom_range(1, 0));
        if (pick < 50)
        begin
            p.from_date = random_valid_date(0, 16383);
            p.to_date   = random_valid_date(0, 16383);
        end
        else if (pick < 75)
        begin
            p.from_date = random_valid_date(1800, 2200);
            p.to_date   = random_valid_date(p.from_date.year,
                                            p.from_date.year + $urandom_range(2, 0));
            if ($urandom_range(9, 0) == 0)
                p.to_date = p.from_date;
        end
        else if (pick < 85)
        begin
            p.to_date   = random_valid_date(0, 3000);
            p.from_date = random_valid_date(p.to_date.year, p.to_date.year + 5);
        end
        else if (pick < 95)
        begin
            p.from_date = random_valid_date(0, 16383);
            p.to_date   = random_valid_date(0, 16383);
            case ($urandom_range(2, 0))
                0:       p.from_date = spoil_date(p.from_date);
                1:       p.to_date = spoil_date(p.to_date);
                default:
                begin
                    p.from_date = spoil_date(p.from_date);
                    p.to_date   = spoil_date(p.to_date);
                end
            endcase
        end
        else
        begin
            p.from_date = make_date($urandom_range(31, 0), $urandom_range(15, 0),
                                    $urandom_range(16383, 0));
            p.to_date   = make_date($urandom_range(31, 0), $urandom_range(15, 0),
                                    $urandom_range(16383, 0));
        end
        return p;
    endfunction

    // Offers one word and waits for the edge that takes it; when idle gaps are on,
    // the valid line drops between bursts for a random number of cycles.
    task automatic send_pair(date_pair_t p);
        int unsigned gap;
        req_if.valid       <= 1'b1;
        req_if.start_day   <= p.from_date.day;
        req_if.start_month <= p.from_date.month;
        req_if.start_year  <= p.from_date.year;
        req_if.end_day     <= p.to_date.day;
        req_if.end_month   <= p.to_date.month;
        req_if.end_year    <= p.to_date.year;
        req_if.include_end <= p.inc;
        @(posedge clk);
        while (!req_if.ready) @(posedge clk);
        sb.note_request(p);
        pairs_sent++;
        if (burst_left > 0)
            burst_left--;
        if (idle_on && burst_left == 0)
        begin
            gap = $urandom_range(6, 1);
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
            burst_left = $urandom_range(12, 1);
        end
    endtask

    task automatic drain_wait();
        req_if.valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() > 0) @(posedge clk);
    endtask

    initial
    begin
        date_pair_t  directed_q[$];
        int unsigned waited;
        sb = new();
        idle_on = 1'b1;
        burst_left = 3;
        stall_style = 1;
        hold_request = 0;
        holds_done = 0;
        pairs_sent = 0;
        rst_n = 1'b0;
        req_if.valid       <= 1'b0;
        req_if.start_day   <= '0;
        req_if.start_month <= '0;
        req_if.start_year  <= '0;
        req_if.end_day     <= '0;
        req_if.end_month   <= '0;
        req_if.end_year    <= '0;
        req_if.include_end <= 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Equal dates, reversed order, the extremes, leap days and bad dates.
        directed_q.push_back(make_pair(15, 6, 2020, 15, 6, 2020, 1'b0));
        directed_q.push_back(make_pair(15, 6, 2020, 15, 6, 2020, 1'b1));
        directed_q.push_back(make_pair(1, 3, 2021, 28, 2, 2021, 1'b0));
        directed_q.push_back(make_pair(1, 3, 2021, 28, 2, 2021, 1'b1));
        directed_q.push_back(make_pair(1, 1, 1, 31, 12, 9999, 1'b0));
        directed_q.push_back(make_pair(1, 1, 0, 31, 12, 16383, 1'b0));
        directed_q.push_back(make_pair(1, 1, 0, 31, 12, 16383, 1'b1));
        directed_q.push_back(make_pair(28, 2, 2000, 1, 3, 2000, 1'b0));
        directed_q.push_back(make_pair(29, 2, 2000, 1, 3, 2000, 1'b1));
        directed_q.push_back(make_pair(29, 2, 1900, 1, 3, 1900, 1'b0));
        directed_q.push_back(make_pair(29, 2, 2004, 29, 2, 2008, 1'b0));
        directed_q.push_back(make_pair(29, 2, 0, 1, 3, 0, 1'b0));
        directed_q.push_back(make_pair(1, 0, 2000, 1, 1, 2001, 1'b1));
        directed_q.push_back(make_pair(1, 1, 2000, 1, 13, 2001, 1'b1));
        directed_q.push_back(make_pair(31, 15, 16383, 31, 15, 16383, 1'b1));
        directed_q.push_back(make_pair(0, 5, 2000, 1, 6, 2000, 1'b0));
        directed_q.push_back(make_pair(31, 4, 2000, 1, 5, 2000, 1'b0));
        directed_q.push_back(make_pair(1, 5, 2010, 31, 4, 2000, 1'b1));
        directed_q.push_back(make_pair(31, 12, 1999, 1, 1, 2000, 1'b0));
        directed_q.push_back(make_pair(31, 1, 16383, 30, 11, 16383, 1'b1));
        directed_q.push_back(make_pair(0, 0, 0, 0, 0, 0, 1'b0));
        foreach (directed_q[i])
            send_pair(directed_q[i]);

        for (int ph = 0; ph < 4; ph++)
        begin
            case (ph)
                0:
                begin
                    idle_on = 1'b1;
                    stall_style = 1;
                end
                1:
                begin
                    idle_on = 1'b0;
                    stall_style = 0;
                end
                2:
                begin
                    idle_on = 1'b1;
                    stall_style = 2;
                end
                default:
                begin
                    idle_on = 1'b1;
                    stall_style = 3;
                end
            endcase
            for (int i = 0; i < 100; i++)
            begin
                // The sender keeps offering during the hold-off, so the pipeline
                // fills and the input stalls.
                if (ph == 1 && i == 40)
                begin
                    hold_request = 80;
                    holds_done++;
                end
                if (ph == 2 && i == 50)
                    drain_wait();
                send_pair(random_pair());
            end
        end

        req_if.valid <= 1'b0;
        waited = 0;
        while (sb.pending() > 0 && waited < 5000)
        begin
            @(posedge clk);
            waited++;
        end
        repeat (8) @(posedge clk);
        if (sb.pending() > 0)
        begin
            $error("%0d expected day counts never returned", sb.pending());
            sb.errors++;
        end

        $display("Sent %0d date pairs and checked %0d result words", pairs_sent, sb.checked);
        $display("(%0d with a bad date, %0d saturated), under varied receiver stalls with %0d %s",
                 sb.invalid_seen, sb.saturated_seen, holds_done,
                 "long hold-off(s) and one drain pause.");
        if (sb.errors == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
